/* design/cau_pkg.sv */
// Shared types, constants and saturation helper for the complex arithmetic unit.
// No dependencies.
package cau_pkg;

    localparam int QW = 33;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_OVF  = 2'd1;
    localparam logic [1:0] ST_DIV0 = 2'd2;

    typedef struct packed {
        logic [1:0]    op;
        logic [31:0]   res_re;
        logic [31:0]   res_im;
        logic          ovf;
        logic          dz;
        logic [63:0]   den;
        logic          neg_re;
        logic          neg_im;
        logic          big_re;
        logic          big_im;
        logic [63:0]   rem_re;
        logic [63:0]   rem_im;
        logic [QW-1:0] dl_re;
        logic [QW-1:0] dl_im;
        logic [QW-1:0] q_re;
        logic [QW-1:0] q_im;
    } item_t;

    typedef struct packed {
        logic [31:0] val;
        logic        ovf;
    } sat_t;

    function automatic sat_t sat_sm(input logic [63:0] mag, input logic neg);
        sat_t r;
        r.ovf = 1'b0;
        if (neg) begin
            if (mag > 64'h0000_0000_8000_0000) begin
                r.ovf = 1'b1;
                r.val = 32'h8000_0000;
            end else begin
                r.val = 32'(64'd0 - mag);
            end
        end else begin
            if (mag > 64'h0000_0000_7FFF_FFFF) begin
                r.ovf = 1'b1;
                r.val = 32'h7FFF_FFFF;
            end else begin
                r.val = mag[31:0];
            end
        end
        return r;
    endfunction

endpackage

/* design/cau_front.sv */
// Front end: products, sums, magnitudes and divider setup over four stages.
// Depends on cau_pkg.
module cau_front
    import cau_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  logic [1:0]         opcode,
    input  logic signed [31:0] a_re,
    input  logic signed [31:0] a_im,
    input  logic signed [31:0] b_re,
    input  logic signed [31:0] b_im,
    output logic               out_valid,
    output item_t              out_item
);

    // stage A
    logic [3:0]         va_reg;
    logic [1:0]         op_a_reg, op_b_reg, op_c_reg;
    logic signed [63:0] p_rr_reg, p_ii_reg, p_ir_reg, p_ri_reg, d_r_reg, d_i_reg;
    logic signed [32:0] as_re_a_reg, as_im_a_reg, as_re_b_reg, as_im_b_reg;
    logic signed [32:0] as_re_c_reg, as_im_c_reg;
    logic signed [63:0] p_rr_next, p_ii_next, p_ir_next, p_ri_next, d_r_next, d_i_next;
    logic signed [32:0] as_re_next, as_im_next;
    // stage B
    logic signed [64:0] s_re_reg, s_im_reg;
    logic signed [64:0] s_re_next, s_im_next;
    logic [63:0]        den_b_reg, den_c_reg;
    // stage C
    logic [63:0]        m_re_reg, m_im_reg;
    logic               n_re_reg, n_im_reg;
    // stage D
    item_t              item_reg, item_next;
    sat_t               ms_re, ms_im;
    logic [63:0]        r0_re, r0_im;

    assign p_rr_next = a_re * b_re;
    assign p_ii_next = a_im * b_im;
    assign p_ir_next = a_im * b_re;
    assign p_ri_next = a_re * b_im;
    assign d_r_next  = b_re * b_re;
    assign d_i_next  = b_im * b_im;
    assign as_re_next = (opcode == OP_SUB) ? (33'(a_re) - 33'(b_re)) : (33'(a_re) + 33'(b_re));
    assign as_im_next = (opcode == OP_SUB) ? (33'(a_im) - 33'(b_im)) : (33'(a_im) + 33'(b_im));

    assign s_re_next = (op_a_reg == OP_MUL) ? (65'(p_rr_reg) - 65'(p_ii_reg))
                                            : (65'(p_rr_reg) + 65'(p_ii_reg));
    assign s_im_next = (op_a_reg == OP_MUL) ? (65'(p_ir_reg) + 65'(p_ri_reg))
                                            : (65'(p_ir_reg) - 65'(p_ri_reg));

    assign r0_re = m_re_reg >> (QW - FRAC_BITS);
    assign r0_im = m_im_reg >> (QW - FRAC_BITS);
    assign ms_re = sat_sm(m_re_reg >> FRAC_BITS, n_re_reg);
    assign ms_im = sat_sm(m_im_reg >> FRAC_BITS, n_im_reg);

    always_comb
    begin
        item_next        = '0;
        item_next.op     = op_c_reg;
        item_next.den    = den_c_reg;
        item_next.dz     = (den_c_reg == 64'd0);
        item_next.neg_re = n_re_reg;
        item_next.neg_im = n_im_reg;
        item_next.rem_re = r0_re;
        item_next.rem_im = r0_im;
        item_next.big_re = (r0_re >= den_c_reg);
        item_next.big_im = (r0_im >= den_c_reg);
        item_next.dl_re  = QW'(m_re_reg[QW-1:0] << FRAC_BITS);
        item_next.dl_im  = QW'(m_im_reg[QW-1:0] << FRAC_BITS);
        if (op_c_reg == OP_MUL) begin
            item_next.res_re = ms_re.val;
            item_next.res_im = ms_im.val;
            item_next.ovf    = ms_re.ovf | ms_im.ovf;
        end else begin
            item_next.res_re = (as_re_c_reg[32] != as_re_c_reg[31])
                ? (as_re_c_reg[32] ? 32'h8000_0000 : 32'h7FFF_FFFF) : as_re_c_reg[31:0];
            item_next.res_im = (as_im_c_reg[32] != as_im_c_reg[31])
                ? (as_im_c_reg[32] ? 32'h8000_0000 : 32'h7FFF_FFFF) : as_im_c_reg[31:0];
            item_next.ovf    = (as_re_c_reg[32] != as_re_c_reg[31])
                             | (as_im_c_reg[32] != as_im_c_reg[31]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            va_reg <= '0;
        end else if (en) begin
            va_reg <= {va_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            op_a_reg    <= opcode;
            p_rr_reg    <= p_rr_next;
            p_ii_reg    <= p_ii_next;
            p_ir_reg    <= p_ir_next;
            p_ri_reg    <= p_ri_next;
            d_r_reg     <= d_r_next;
            d_i_reg     <= d_i_next;
            as_re_a_reg <= as_re_next;
            as_im_a_reg <= as_im_next;

            op_b_reg    <= op_a_reg;
            s_re_reg    <= s_re_next;
            s_im_reg    <= s_im_next;
            den_b_reg   <= 64'(d_r_reg) + 64'(d_i_reg);
            as_re_b_reg <= as_re_a_reg;
            as_im_b_reg <= as_im_a_reg;

            op_c_reg    <= op_b_reg;
            m_re_reg    <= s_re_reg[64] ? 64'(-s_re_reg) : 64'(s_re_reg);
            m_im_reg    <= s_im_reg[64] ? 64'(-s_im_reg) : 64'(s_im_reg);
            n_re_reg    <= s_re_reg[64];
            n_im_reg    <= s_im_reg[64];
            den_c_reg   <= den_b_reg;
            as_re_c_reg <= as_re_b_reg;
            as_im_c_reg <= as_im_b_reg;

            item_reg    <= item_next;
        end
    end

    assign out_valid = va_reg[3];
    assign out_item  = item_reg;

endmodule

/* design/cau_div_cell.sv */
// One restoring-divide cell: one quotient bit for both parts per transaction.
// Depends on cau_pkg.
module cau_div_cell
    import cau_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  en,
    input  logic  in_valid,
    input  item_t in_item,
    output logic  out_valid,
    output item_t out_item
);

    logic        valid_reg;
    item_t       item_reg, item_next;
    logic [64:0] sh_re, sh_im;
    logic        ge_re, ge_im;

    assign sh_re = {in_item.rem_re, in_item.dl_re[QW-1]};
    assign sh_im = {in_item.rem_im, in_item.dl_im[QW-1]};
    assign ge_re = (sh_re >= {1'b0, in_item.den});
    assign ge_im = (sh_im >= {1'b0, in_item.den});

    always_comb
    begin
        item_next        = in_item;
        item_next.rem_re = ge_re ? 64'(sh_re - {1'b0, in_item.den}) : sh_re[63:0];
        item_next.rem_im = ge_im ? 64'(sh_im - {1'b0, in_item.den}) : sh_im[63:0];
        item_next.dl_re  = {in_item.dl_re[QW-2:0], 1'b0};
        item_next.dl_im  = {in_item.dl_im[QW-2:0], 1'b0};
        item_next.q_re   = {in_item.q_re[QW-2:0], ge_re};
        item_next.q_im   = {in_item.q_im[QW-2:0], ge_im};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

/* design/complex_arith_unit.sv */
// Pipeline: 4 front stages, 33 divide cells, 1 output register.
// One transaction per cycle unless stalled; the divide chain sets the depth.
// All ops flow through the same pipeline, which stalls as a whole on m_tready.
// Reset clears all valid flags; payload registers are not reset.
// Depends on cau_pkg, cau_front, cau_div_cell.
module complex_arith_unit
    import cau_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,  // a_re, a_im, b_re, b_im
    input  logic [1:0]   s_tuser,  // opcode
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [63:0]  m_tdata,  // res_re, res_im
    output logic [1:0]   m_tuser   // status
);

    logic        en;
    logic        cv [QW+1];
    item_t       ci [QW+1];
    logic        m_tvalid_reg;
    logic [31:0] re_reg, im_reg, re_next, im_next;
    logic [1:0]  st_reg, st_next;
    item_t       fin;
    sat_t        qs_re, qs_im;

    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;

    cau_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (s_tvalid),
        .opcode   (s_tuser),
        .a_re     (s_tdata[31:0]),
        .a_im     (s_tdata[63:32]),
        .b_re     (s_tdata[95:64]),
        .b_im     (s_tdata[127:96]),
        .out_valid(cv[0]),
        .out_item (ci[0])
    );

    for (genvar g = 0; g < QW; g++) begin : g_cell
        cau_div_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .in_valid (cv[g]),
            .in_item  (ci[g]),
            .out_valid(cv[g+1]),
            .out_item (ci[g+1])
        );
    end

    assign fin   = ci[QW];
    assign qs_re = sat_sm(64'(fin.q_re), fin.neg_re);
    assign qs_im = sat_sm(64'(fin.q_im), fin.neg_im);

    always_comb
    begin
        re_next = fin.res_re;
        im_next = fin.res_im;
        st_next = fin.ovf ? ST_OVF : ST_OK;
        if (fin.op == OP_DIV) begin
            if (fin.dz) begin
                re_next = '0;
                im_next = '0;
                st_next = ST_DIV0;
            end else begin
                re_next = fin.big_re ? (fin.neg_re ? 32'h8000_0000 : 32'h7FFF_FFFF)
                                     : qs_re.val;
                im_next = fin.big_im ? (fin.neg_im ? 32'h8000_0000 : 32'h7FFF_FFFF)
                                     : qs_im.val;
                st_next = (fin.big_re | fin.big_im | qs_re.ovf | qs_im.ovf) ? ST_OVF : ST_OK;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= cv[QW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            re_reg <= re_next;
            im_reg <= im_next;
            st_reg <= st_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {im_reg, re_reg};
    assign m_tuser  = st_reg;

endmodule

/* bench/complex_arith_unit_tb.sv */
// Testbench for complex_arith_unit: directed table, then random operand streams,
// checked against table results or a predictor. Depends on cau_pkg and the RTL.
module complex_arith_unit_tb
    import cau_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC = 16;
    localparam int N_RANDOM = 1700;

    typedef struct {
        logic [31:0] re;
        logic [31:0] im;
        logic [1:0]  st;
    } cplx_res_t;

    typedef struct {
        op_t         op;
        logic [31:0] ar;
        logic [31:0] ai;
        logic [31:0] br;
        logic [31:0] bi;
        bit          typed;
        cplx_res_t   res;
    } vec_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [127:0] s_tdata;   // a_re, a_im, b_re, b_im
    logic [1:0]   s_tuser;   // opcode
    logic         m_tvalid;
    logic         m_tready;
    logic [63:0]  m_tdata;   // res_re, res_im
    logic [1:0]   m_tuser;   // status

    cplx_res_t pending_results[$];
    int        errors = 0;
    int        src_idle = 0;
    int        dst_idle = 0;
    int        hold_cycles = 0;

    complex_arith_unit i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("complex_arith_unit test failed");
        $finish;
    end

    function automatic logic [32:0] clamp32(input logic signed [97:0] v);
        if (v > 98'sd2147483647)
            return {1'b1, 32'h7FFF_FFFF};
        else if (v < -98'sd2147483648)
            return {1'b1, 32'h8000_0000};
        else
            return {1'b0, v[31:0]};
    endfunction

    function automatic cplx_res_t predict_cplx(input op_t op, input logic [31:0] ar,
                                               input logic [31:0] ai, input logic [31:0] br,
                                               input logic [31:0] bi);
        logic signed [97:0] xr, xi, yr, yi, nr, ni, den;
        logic [32:0]        sr, si;
        cplx_res_t          r;
        xr = $signed(ar);
        xi = $signed(ai);
        yr = $signed(br);
        yi = $signed(bi);
        r.st = ST_OK;
        den = 1;
        case (op)
            OP_ADD:
            begin
                nr = xr + yr;
                ni = xi + yi;
            end
            OP_SUB:
            begin
                nr = xr - yr;
                ni = xi - yi;
            end
            OP_MUL:
            begin
                nr = (xr * yr - xi * yi) / (98'sd1 <<< FRAC);
                ni = (xi * yr + xr * yi) / (98'sd1 <<< FRAC);
            end
            default:
            begin
                den = yr * yr + yi * yi;
                if (den != 0)
                begin
                    nr = ((xr * yr + xi * yi) <<< FRAC) / den;
                    ni = ((xi * yr - xr * yi) <<< FRAC) / den;
                end
            end
        endcase
        if (den == 0)
        begin
            r.re = '0;
            r.im = '0;
            r.st = ST_DIV0;
        end
        else
        begin
            sr = clamp32(nr);
            si = clamp32(ni);
            r.re = sr[31:0];
            r.im = si[31:0];
            if (sr[32] || si[32])
                r.st = ST_OVF;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] exp_v,
                                   input logic [31:0] got_v);
        $display("mismatch %s: expected %h got %h at %0t", what, exp_v, got_v, $realtime);
        errors++;
    endtask

    task automatic send_op(input vec_t v);
        @(negedge clk);
        while ($urandom_range(99) < src_idle)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= v.op;
        s_tdata  <= {v.bi, v.br, v.ai, v.ar};
        do
            @(posedge clk);
        while (!s_tready);
        pending_results.push_back(v.typed ? v.res
                                          : predict_cplx(v.op, v.ar, v.ai, v.br, v.bi));
    endtask

    function automatic logic [31:0] rand_operand();
        case ($urandom_range(5))
            0: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            1: return 32'($signed($urandom_range(16'hFFFF)) - 32'sh8000);
            2: return 32'($signed($urandom_range(32'h3FF_FFFF)) - 32'sh200_0000);
            3: return '0;
            default: return $urandom;
        endcase
    endfunction

    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            m_tready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end
        else
            m_tready <= ($urandom_range(99) >= dst_idle);
    end

    always @(posedge clk)
    begin
        cplx_res_t e;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("unexpected transaction at %0t", $realtime);
                errors++;
            end
            else
            begin
                e = pending_results.pop_front();
                if (m_tdata[31:0] !== e.re)
                    report_mismatch("res_re", e.re, m_tdata[31:0]);
                if (m_tdata[63:32] !== e.im)
                    report_mismatch("res_im", e.im, m_tdata[63:32]);
                if (m_tuser !== e.st)
                    report_mismatch("status", 32'(e.st), 32'(m_tuser));
            end
        end
    end

    vec_t directed[] = '{
        '{OP_ADD, 32'h0, 32'h0, 32'h0, 32'h0, 1, '{32'h0, 32'h0, ST_OK}},
        '{OP_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1, 32'hFFFF_FFFF, 1,
          '{32'h7FFF_FFFF, 32'h8000_0000, ST_OVF}},
        '{OP_SUB, 32'h8000_0000, 32'h7FFF_FFFF, 32'h1, 32'hFFFF_FFFF, 1,
          '{32'h8000_0000, 32'h7FFF_FFFF, ST_OVF}},
        '{OP_DIV, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0, 1, '{32'h0, 32'h0, ST_DIV0}},
        '{OP_DIV, 32'h0, 32'h0, 32'h0, 32'h0, 1, '{32'h0, 32'h0, ST_DIV0}},
        '{OP_ADD, 32'h0001_8000, 32'hFFFF_0000, 32'h0000_4000, 32'h0002_0000, 0, '{0, 0, 0}},
        '{OP_SUB, 32'h0001_8000, 32'hFFFF_0000, 32'h0000_4000, 32'h0002_0000, 0, '{0, 0, 0}},
        '{OP_MUL, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'hFFFC_0000, 0, '{0, 0, 0}},
        '{OP_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, '{0, 0, 0}},
        '{OP_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 0, '{0, 0, 0}},
        '{OP_MUL, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0001, 32'hFFFF_FFFF, 0, '{0, 0, 0}},
        '{OP_DIV, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'hFFFC_0000, 0, '{0, 0, 0}},
        '{OP_DIV, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0001, 32'h0, 0, '{0, 0, 0}},
        '{OP_DIV, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, '{0, 0, 0}},
        '{OP_DIV, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0003, 32'h0, 0, '{0, 0, 0}},
        '{OP_DIV, 32'h0000_0001, 32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, '{0, 0, 0}}
    };

    initial
    begin
        vec_t v;
        int   wait_cycles;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = OP_ADD;
        m_tready = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed[i])
            send_op(directed[i]);

        for (int n = 0; n < N_RANDOM; n++)
        begin
            if (n == 0)
            begin
                src_idle = 13;
                dst_idle = 49;
            end
            else if (n == N_RANDOM / 3)
            begin
                src_idle = 49;
                dst_idle = 13;
            end
            else if (n == 2 * N_RANDOM / 3)
            begin
                src_idle = 0;
                dst_idle = 0;
                hold_cycles = 300;
            end
            v.op    = op_t'($urandom_range(3));
            v.ar    = rand_operand();
            v.ai    = rand_operand();
            v.br    = rand_operand();
            v.bi    = rand_operand();
            v.typed = 0;
            send_op(v);
        end
        @(negedge clk);
        s_tvalid <= 1'b0;

        wait_cycles = 0;
        while (pending_results.size() != 0 && wait_cycles < 100000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (60) @(posedge clk);
        if (errors == 0 && pending_results.size() == 0)
            $display("complex_arith_unit test passed");
        else
            $display("complex_arith_unit test failed");
        $finish;
    end
endmodule

/* filelist.f */
design/cau_pkg.sv
design/cau_front.sv
design/cau_div_cell.sv
design/complex_arith_unit.sv
bench/complex_arith_unit_tb.sv
